/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check uses the clock clk and is
// disabled while the asynchronous reset arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/psmh_pkg.sv */
// ----------------------------------------------------------------------------
// psmh_pkg
// Types and constants of the pair-sum min-heap: heap size, entry layout,
// status codes, command codes and controller states.
// ----------------------------------------------------------------------------
package psmh_pkg;

	localparam int CAP    = 1024;
	localparam int AW     = $clog2(CAP);
	localparam int CW     = $clog2(CAP + 1);
	localparam int IW     = AW + 2;
	localparam int VAL_W  = 16;
	localparam int KEY_W  = VAL_W + 1;
	localparam int ENT_W  = KEY_W + VAL_W;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] first;
	} entry_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_POP_ROOT,
		S_POP_LAST,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_RESP
	} state_t;

endpackage

/* rtl/core/psmh_ram.sv */
// ----------------------------------------------------------------------------
// psmh_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module psmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/pair_sum_min_heap.sv */
// Insert: the new entry is sifted up, one level per parent read and compare.
// Pop: the root is read out, then the last entry is sifted down from the root, level by level.
// One item at a time; the single read port of the heap memory sets the pace.
// Rejected items (full or empty) go straight to the response state, a pop of the last entry after the root read.
// Reset clears the entry count and the control state; the heap memory is not
// cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
// pair_sum_min_heap
// Binary min-heap of value pairs keyed by their sum, held in one RAM, with
// sift-up on insert and sift-down on pop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pair_sum_min_heap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        cmd,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic signed [15:0] popped_first,
	output logic signed [15:0] popped_second,
	output logic [1:0]  status
);

	psmh_pkg::state_t state_q, state_d;
	logic [psmh_pkg::CW-1:0] count_q;
	logic [psmh_pkg::AW-1:0] pos_q;
	psmh_pkg::entry_t x_q, lk_q, rd_ent, pick_ent;
	logic right_q;
	logic [psmh_pkg::VAL_W-1:0] res_first_q, res_second_q;
	psmh_pkg::status_t res_status_q;
	logic rsp_valid_q;
	logic [psmh_pkg::VAL_W-1:0] out_first_q, out_second_q;
	logic [1:0] out_status_q;

	logic we;
	logic [psmh_pkg::AW-1:0] waddr, raddr;
	psmh_pkg::entry_t wdata;
	logic [psmh_pkg::ENT_W-1:0] ram_rdata;

	logic req_fire, is_full, is_empty, use_right;
	logic [psmh_pkg::AW-1:0] pos_m1, parent, count_m1, pick_idx;
	logic [psmh_pkg::IW-1:0] left, right, count_x;
	logic signed [psmh_pkg::KEY_W-1:0] new_key;

	assign req_ready = (state_q == psmh_pkg::S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign is_full   = (count_q == psmh_pkg::CW'(psmh_pkg::CAP));
	assign is_empty  = (count_q == '0);

	assign rd_ent   = psmh_pkg::entry_t'(ram_rdata);
	assign pos_m1   = pos_q - 1'b1;
	assign parent   = {1'b0, pos_m1[psmh_pkg::AW-1:1]};
	assign count_m1 = psmh_pkg::AW'(count_q - 1'b1);
	assign left     = {1'b0, pos_q, 1'b1};
	assign right    = left + 1'b1;
	assign count_x  = psmh_pkg::IW'(count_q);
	assign new_key  = {first_value[15], first_value} + {second_value[15], second_value};

	// The right child wins ties, as in the sift-down rule.
	assign use_right = right_q && (rd_ent.key <= lk_q.key);
	assign pick_ent  = use_right ? rd_ent : lk_q;
	assign pick_idx  = use_right ? right[psmh_pkg::AW-1:0] : left[psmh_pkg::AW-1:0];

	psmh_ram #(
		.WIDTH(psmh_pkg::ENT_W),
		.DEPTH(psmh_pkg::CAP)
	) u_heap_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psmh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The moving entry stays in x_q while a hole walks through the array, so
	// each level costs one write instead of a full swap.
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = x_q;
		raddr   = '0;
		unique case (state_q)
			psmh_pkg::S_IDLE: begin
				if (req_fire) begin
					if (cmd == psmh_pkg::CMD_INSERT) begin
						state_d = is_full ? psmh_pkg::S_RESP : psmh_pkg::S_UP_RD;
					end else begin
						state_d = is_empty ? psmh_pkg::S_RESP : psmh_pkg::S_POP_ROOT;
					end
				end
			end
			psmh_pkg::S_UP_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = psmh_pkg::S_RESP;
				end else begin
					raddr   = parent;
					state_d = psmh_pkg::S_UP_CMP;
				end
			end
			psmh_pkg::S_UP_CMP: begin
				we = 1'b1;
				if (x_q.key <= rd_ent.key) begin
					wdata   = rd_ent;
					state_d = psmh_pkg::S_UP_RD;
				end else begin
					state_d = psmh_pkg::S_RESP;
				end
			end
			psmh_pkg::S_POP_ROOT: begin
				raddr   = count_m1;
				state_d = (count_q == psmh_pkg::CW'(1)) ? psmh_pkg::S_RESP
				                                         : psmh_pkg::S_POP_LAST;
			end
			psmh_pkg::S_POP_LAST: begin
				state_d = psmh_pkg::S_DN_RDL;
			end
			psmh_pkg::S_DN_RDL: begin
				if (left >= count_x) begin
					we      = 1'b1;
					state_d = psmh_pkg::S_RESP;
				end else begin
					raddr   = left[psmh_pkg::AW-1:0];
					state_d = psmh_pkg::S_DN_RDR;
				end
			end
			psmh_pkg::S_DN_RDR: begin
				raddr   = right[psmh_pkg::AW-1:0];
				state_d = psmh_pkg::S_DN_CMP;
			end
			psmh_pkg::S_DN_CMP: begin
				we = 1'b1;
				if (x_q.key <= pick_ent.key) begin
					state_d = psmh_pkg::S_RESP;
				end else begin
					wdata   = pick_ent;
					state_d = psmh_pkg::S_DN_RDL;
				end
			end
			psmh_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = psmh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = psmh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire && cmd == psmh_pkg::CMD_INSERT && !is_full) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == psmh_pkg::S_POP_ROOT) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == psmh_pkg::S_RESP && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			psmh_pkg::S_IDLE: begin
				if (req_fire) begin
					x_q.key      <= new_key;
					x_q.first    <= first_value;
					pos_q        <= count_q[psmh_pkg::AW-1:0];
					res_first_q  <= '0;
					res_second_q <= '0;
					if (cmd == psmh_pkg::CMD_INSERT) begin
						res_status_q <= is_full ? psmh_pkg::ST_FULL : psmh_pkg::ST_INSERTED;
					end else begin
						res_status_q <= is_empty ? psmh_pkg::ST_EMPTY : psmh_pkg::ST_POPPED;
					end
				end
			end
			psmh_pkg::S_UP_CMP: begin
				if (x_q.key <= rd_ent.key) begin
					pos_q <= parent;
				end
			end
			psmh_pkg::S_POP_ROOT: begin
				res_first_q  <= rd_ent.first;
				res_second_q <= rd_ent.key[psmh_pkg::VAL_W-1:0] - rd_ent.first;
			end
			psmh_pkg::S_POP_LAST: begin
				x_q   <= rd_ent;
				pos_q <= '0;
			end
			psmh_pkg::S_DN_RDR: begin
				lk_q    <= rd_ent;
				right_q <= (right < count_x);
			end
			psmh_pkg::S_DN_CMP: begin
				if (!(x_q.key <= pick_ent.key)) begin
					pos_q <= pick_idx;
				end
			end
			psmh_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_first_q  <= res_first_q;
					out_second_q <= res_second_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid     = rsp_valid_q;
	assign popped_first  = out_first_q;
	assign popped_second = out_second_q;
	assign status        = out_status_q;

	`ASSERT_SAME(a_count_bound, 1'b1, count_q <= psmh_pkg::CW'(psmh_pkg::CAP), "entry count above capacity")
	`ASSERT_NEXT(a_insert_count, req_fire && cmd == psmh_pkg::CMD_INSERT && !is_full, count_q == $past(count_q) + 1'b1, "accepted insert did not bump the count")
	`ASSERT_SAME(a_write_in_heap, we, psmh_pkg::CW'(waddr) < count_q, "heap write outside live entries")
	`ASSERT_SAME(a_idle_no_write, state_q == psmh_pkg::S_IDLE, !we, "heap write while idle")

endmodule
